@@ design/yiq_hue_rotate_assert.svh @@
// Assertion macros shared by the yiq_hue_rotate checker.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef YIQ_HUE_ROTATE_ASSERT_SVH
`define YIQ_HUE_ROTATE_ASSERT_SVH

// Same-cycle implication, off during reset
`define YHR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("yhr: implication check failed");

// Next-cycle implication, off during reset
`define YHR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("yhr: next-cycle check failed");

// Check the cycle after a reset edge
`define YHR_ASSERT_RST(lbl, cons) \
    lbl: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) \
        else $error("yhr: reset check failed");

`endif

@@ design/yhr_pkg.sv @@
// Package for yiq_hue_rotate: matrix coefficients, register codes, fixed-point helper.
// No dependencies.
`default_nettype none

package yhr_pkg;

    // Fraction bits of the cosine and sine registers
    localparam int TRIG_FRAC_BITS = 14;

    // Register codes on the configuration port
    typedef enum logic {
        REG_COS = 1'b0,
        REG_SIN = 1'b1
    } t_reg_idx;

    // RGB to YIQ, in thousandths
    localparam int FWD_MILLI [3][3] = '{
        '{ 299,  587,  114},
        '{ 596, -274, -321},
        '{ 211, -523,  311}
    };

    // YIQ to RGB, in thousandths
    localparam int INV_MILLI [3][3] = '{
        '{1000,   956,  621},
        '{1000,  -272, -647},
        '{1000, -1107, 1705}
    };

    // Scale thousandths by 2^frac, rounding half away from zero
    function automatic longint to_fixed(input int milli, input int frac);
        longint mag;
        longint q;
        mag = (milli < 0) ? -longint'(milli) : longint'(milli);
        q   = (mag * (longint'(1) << frac) + 64'sd500) / 1000;
        return (milli < 0) ? -q : q;
    endfunction

endpackage

`default_nettype wire

@@ design/yhr_fifo.sv @@
// Two-entry queue between the front and the back of yiq_hue_rotate.
// No package dependencies.
`default_nettype none

module yhr_fifo #(
    parameter int W = 72
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [W-1:0] i_data,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [W-1:0]      o_data
);

    logic [W-1:0] r_ent0;
    logic [W-1:0] r_ent1;
    logic         r_wptr;
    logic         r_rptr;
    logic [1:0]   r_cnt;
    logic         push;
    logic         pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_rptr ? r_ent1 : r_ent0;
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // Store on push
    always_ff @(posedge i_clk) begin
        if (push && !r_wptr) begin
            r_ent0 <= i_data;
        end
        if (push && r_wptr) begin
            r_ent1 <= i_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/yhr_front.sv @@
// Front of yiq_hue_rotate: takes RGB pixels and converts them to scaled YIQ.
// Depends on yhr_pkg.
`default_nettype none

module yhr_front #(
    parameter  int COEF_FRAC_BITS = 14,
    localparam int YW             = COEF_FRAC_BITS + 10
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [7:0]      i_red,
    input  wire logic [7:0]      i_green,
    input  wire logic [7:0]      i_blue,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [3*YW-1:0]      o_yiq
);

    import yhr_pkg::*;

    logic                 r_valid;
    logic signed [YW-1:0] r_yiq [3];
    logic signed [YW-1:0] n_yiq [3];
    logic signed [YW-1:0] px [3];
    logic                 take;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_yiq   = {r_yiq[0], r_yiq[1], r_yiq[2]};
    assign take    = i_valid && o_ready;

    // Forward matrix: each row is three constant products and a sum
    always_comb begin
        px[0] = YW'($signed({1'b0, i_red}));
        px[1] = YW'($signed({1'b0, i_green}));
        px[2] = YW'($signed({1'b0, i_blue}));
        for (int r = 0; r < 3; r++) begin
            n_yiq[r] = '0;
            for (int c = 0; c < 3; c++) begin
                n_yiq[r] = n_yiq[r]
                         + px[c] * YW'(to_fixed(FWD_MILLI[r][c], COEF_FRAC_BITS));
            end
        end
    end

    // Load YIQ on transfer
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_yiq <= n_yiq;
        end
    end

    // Hold valid until the queue takes the item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

endmodule

`default_nettype wire

@@ design/yhr_back.sv @@
// Back of yiq_hue_rotate: rotates I and Q, converts back to RGB and clamps.
// Four pipeline stages with per-stage flow control. Depends on yhr_pkg.
`default_nettype none

module yhr_back #(
    parameter  int COEF_FRAC_BITS = 14,
    localparam int YW             = COEF_FRAC_BITS + 10
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic signed [15:0] i_cos,
    input  wire logic signed [15:0] i_sin,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [3*YW-1:0]    i_yiq,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [7:0]              o_red,
    output logic [7:0]              o_green,
    output logic [7:0]              o_blue
);

    import yhr_pkg::*;

    localparam int F  = COEF_FRAC_BITS;
    localparam int PW = YW + 16;
    localparam int RW = F + 12;
    localparam int AW = 2 * F + 16;

    logic signed [YW-1:0] in_y;
    logic signed [YW-1:0] in_i;
    logic signed [YW-1:0] in_q;

    logic                 r_v1;
    logic                 r_v2;
    logic                 r_v3;
    logic                 r_vo;
    logic                 rdy1;
    logic                 rdy2;
    logic                 rdy3;
    logic                 rdyo;

    logic signed [YW-1:0] r_y1;
    logic signed [PW-1:0] r_pci;
    logic signed [PW-1:0] r_psq;
    logic signed [PW-1:0] r_psi;
    logic signed [PW-1:0] r_pcq;

    logic signed [RW-1:0] r_rot [3];
    logic signed [RW-1:0] n_rot [3];

    logic signed [AW-1:0] r_prod [3][3];
    logic signed [AW-1:0] sum [3];
    logic [7:0]           n_out [3];
    logic [7:0]           r_out [3];

    assign {in_y, in_i, in_q} = i_yiq;

    // Stage ready chain
    assign rdyo    = !r_vo || i_ready;
    assign rdy3    = !r_v3 || rdyo;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    assign o_valid = r_vo;
    assign o_red   = r_out[0];
    assign o_green = r_out[1];
    assign o_blue  = r_out[2];

    // Valid bits of the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdyo) begin
                r_vo <= r_v3;
            end
        end
    end

    // Stage 1: four rotation products
    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_y1  <= in_y;
            r_pci <= PW'(i_cos) * PW'(in_i);
            r_psq <= PW'(i_sin) * PW'(in_q);
            r_psi <= PW'(i_sin) * PW'(in_i);
            r_pcq <= PW'(i_cos) * PW'(in_q);
        end
    end

    // Stage 2: combine and floor back to the matrix scale
    always_comb begin
        n_rot[0] = RW'(r_y1);
        n_rot[1] = RW'((r_pci - r_psq) >>> TRIG_FRAC_BITS);
        n_rot[2] = RW'((r_psi + r_pcq) >>> TRIG_FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            r_rot <= n_rot;
        end
    end

    // Stage 3: inverse matrix products
    always_ff @(posedge i_clk) begin
        if (rdy3 && r_v2) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[r][c] <= AW'(to_fixed(INV_MILLI[r][c], COEF_FRAC_BITS))
                                  * AW'(r_rot[c]);
                end
            end
        end
    end

    // Stage 4: sum each row, clamp to 0..255 after dropping 2F fraction bits
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            sum[r] = r_prod[r][0] + r_prod[r][1] + r_prod[r][2];
            if (sum[r][AW-1] || (sum[r] == '0)) begin
                n_out[r] = 8'd0;
            end else if (|sum[r][AW-2:2*F+8]) begin
                n_out[r] = 8'd255;
            end else begin
                n_out[r] = sum[r][2*F+7:2*F];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdyo && r_v3) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

@@ design/yiq_hue_rotate.sv @@
// Hue rotation of RGB pixels in YIQ space.
// Input passes the front register, the queue and four back stages before the result is valid.
// Throughput: one pixel per cycle while the output does not stall, set by the pipelined back matrix.
// The two-entry queue lets the front keep taking pixels while the output stalls.
// Reset (synchronous, active low) empties all stages; cosine resets to 1.0, sine to 0.
`default_nettype none

module yiq_hue_rotate #(
    parameter int COEF_FRAC_BITS = 14
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Pixel input
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_red_in,
    input  wire logic [7:0]  i_green_in,
    input  wire logic [7:0]  i_blue_in,
    // Pixel output
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_red_out,
    output logic [7:0]       o_green_out,
    output logic [7:0]       o_blue_out,
    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    import yhr_pkg::*;

    localparam int YW = COEF_FRAC_BITS + 10;

    logic signed [15:0] r_cos;
    logic signed [15:0] r_sin;
    t_reg_idx           reg_idx;
    logic               cfg_wr;

    logic               fr_valid;
    logic               fr_ready;
    logic [3*YW-1:0]    fr_yiq;
    logic               q_valid;
    logic               q_ready;
    logic [3*YW-1:0]    q_yiq;

    // Register access
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        case (reg_idx)
            REG_COS: prdata = 32'(r_cos);
            REG_SIN: prdata = 32'(r_sin);
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos <= 16'sd16384;
            r_sin <= 16'sd0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_COS: r_cos <= pwdata[15:0];
                REG_SIN: r_sin <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    yhr_front #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_red   (i_red_in),
        .i_green (i_green_in),
        .i_blue  (i_blue_in),
        .o_valid (fr_valid),
        .i_ready (fr_ready),
        .o_yiq   (fr_yiq)
    );

    yhr_fifo #(
        .W (3 * YW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (fr_ready),
        .i_data  (fr_yiq),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_yiq)
    );

    yhr_back #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cos   (r_cos),
        .i_sin   (r_sin),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_yiq   (q_yiq),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_red   (o_red_out),
        .o_green (o_green_out),
        .o_blue  (o_blue_out)
    );

endmodule

`default_nettype wire

@@ design/yhr_checker.sv @@
// Port-level checker for yiq_hue_rotate and the bind that attaches it.
// Depends on yiq_hue_rotate_assert.svh.
`default_nettype none

`include "yiq_hue_rotate_assert.svh"

module yhr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [7:0]  o_red_out,
    input wire logic [7:0]  o_green_out,
    input wire logic [7:0]  o_blue_out
);

    // Front register, two queue entries, four back stages
    localparam logic [3:0] CAPACITY = 4'd7;

    logic [3:0]  r_cnt;
    logic        in_xfer;
    logic        out_xfer;
    logic [23:0] out_px;

    assign in_xfer  = i_valid && o_ready;
    assign out_xfer = o_valid && i_ready;
    assign out_px   = {o_red_out, o_green_out, o_blue_out};

    // Track pixels inside the block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 4'd0;
        end else if (in_xfer && !out_xfer) begin
            r_cnt <= r_cnt + 4'd1;
        end else if (out_xfer && !in_xfer) begin
            r_cnt <= r_cnt - 4'd1;
        end
    end

    `YHR_ASSERT_RST(a_reset_empty, !o_valid)
    `YHR_ASSERT_IMP(a_no_invented_result, o_valid, r_cnt != 4'd0)
    `YHR_ASSERT_IMP(a_capacity_bound, 1'b1, r_cnt <= CAPACITY)
    `YHR_ASSERT_NXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(out_px))

endmodule

bind yiq_hue_rotate yhr_checker u_yhr_checker (.*);

`default_nettype wire
